// File: sv/smpg_pkg.sv
// shared types and constants for the serial mouse packet generator
// depends on nothing; every other file refers to it by scoped names
package smpg_pkg;

  // coordinate width of the stored positions
  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SPEED_BITS = 9;
  localparam int LAT_BITS   = 11;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // input action codes
  localparam logic [1:0] ACT_POSITION = 2'd0;
  localparam logic [1:0] ACT_LINE     = 2'd1;
  localparam logic [1:0] ACT_TICK     = 2'd2;
  localparam logic [1:0] ACT_RECENTRE = 2'd3;

  // result kind codes
  localparam logic [1:0] KIND_PACKET  = 2'd0;
  localparam logic [1:0] KIND_FRAMING = 2'd1;
  localparam logic [1:0] KIND_PARITY  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SPEED_MUL     = 2'd0;
  localparam logic [1:0] REG_SWAP_BUTTONS  = 2'd1;
  localparam logic [1:0] REG_PORT_SELECT   = 2'd2;
  localparam logic [1:0] REG_LATENCY_TICKS = 2'd3;

  // reset values of the registers
  localparam logic [SPEED_BITS-1:0] SPEED_RESET   = SPEED_BITS'(205);
  localparam logic [1:0]            PORT_RESET    = 2'd1;
  localparam logic [LAT_BITS-1:0]   LATENCY_RESET = LAT_BITS'(725 * 2);

  // receiver settings that a packet needs
  localparam logic [3:0] CHAR_BITS_OK = 4'd8;
  localparam logic [1:0] STOP_TWO     = 2'd3;
  localparam logic [1:0] PARITY_NONE  = 2'd0;

  // one queued command: a packet or an error report
  typedef struct packed {
    logic [1:0]                  kind;
    logic [1:0]                  buttons;
    logic signed [DIFF_BITS-1:0] dx;
    logic signed [DIFF_BITS-1:0] dy;
  } cmd_t;

  // 16-bit input position to stored coordinate width
  function automatic logic signed [COORD_BITS-1:0] coord_from16(logic signed [15:0] v);
    logic signed [31:0] w;
    w = 32'(v);
    return COORD_BITS'(w);
  endfunction

endpackage

// File: sv/serial_mouse_packet_generator.sv
// Serial mouse packet generator, top level.
// Input stream s_*: one item per transaction, action code in s_tuser.
// Position items store the absolute pointer and buttons; a falling edge of
// the request line on the selected port starts the latency countdown of
// latency_ticks tick items. At expiry the receiver settings in the tick item
// decide: a framing error, a parity error, silence, or a three-byte packet
// (status, dx, dy) on the output stream m_*, kind in m_tuser, m_tlast on the
// final byte of each run.
// Config channel cfg_*: index 0 speed_mul, 1 swap_buttons, 2 port_select,
// 3 latency_ticks; always ready; the user must write it only while the block is idle, which it does not enforce.
// Throughput: one input item per cycle while the command queue has room; the
// front's state is registered. A packet occupies the output for three transactions.
// Path: the command of the expiring tick passes the queue register, the
// multiply stage and the output shift register before the first result byte.
// When the receiver stalls, results wait in the output shift register,
// the product stage and a four-entry command queue; s_tready drops only
// when that queue is full. Reset sets the control state and the config
// registers to their reset values; no result is pending after reset.
// Uses smpg_pkg, smpg_front, smpg_queue, smpg_back.
module serial_mouse_packet_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pos_x[15:0], pos_y[31:16], buttons[33:32], line_level[34], line_port[36:35],
  // rx_enabled[37], rate_is_4800[38], char_bits[42:39], stop_code[44:43],
  // parity_mode[46:45], rx_empty[47]
  input  logic [47:0] s_tdata,
  // action[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // data_byte[7:0]
  output logic [7:0]  m_tdata,
  // kind[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  logic [smpg_pkg::SPEED_BITS-1:0] speed_mul;
  logic                            push, q_ready, q_valid, q_pop;
  smpg_pkg::cmd_t                  push_cmd, q_cmd;

  assign cfg_ready = 1'b1;

  // front: classify items, hold state
  smpg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (s_tvalid),
    .item_ready   (s_tready),
    .action       (s_tuser),
    .pos_x        (s_tdata[15:0]),
    .pos_y        (s_tdata[31:16]),
    .buttons      (s_tdata[33:32]),
    .line_level   (s_tdata[34]),
    .line_port    (s_tdata[36:35]),
    .rx_enabled   (s_tdata[37]),
    .rate_is_4800 (s_tdata[38]),
    .char_bits    (s_tdata[42:39]),
    .stop_code    (s_tdata[44:43]),
    .parity_mode  (s_tdata[46:45]),
    .rx_empty     (s_tdata[47]),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .speed_mul    (speed_mul),
    .push         (push),
    .push_cmd     (push_cmd),
    .q_ready      (q_ready)
  );

  // command queue
  smpg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd)
  );

  // back: scale, saturate, serialize
  smpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .speed_mul (speed_mul),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// File: sv/smpg_front.sv
// front part: config registers, position state, request edge and countdown
// decides at expiry what to report and pushes a command; uses smpg_pkg
module smpg_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [1:0]                     action,
  input  logic signed [15:0]             pos_x,
  input  logic signed [15:0]             pos_y,
  input  logic [1:0]                     buttons,
  input  logic                           line_level,
  input  logic [1:0]                     line_port,
  input  logic                           rx_enabled,
  input  logic                           rate_is_4800,
  input  logic [3:0]                     char_bits,
  input  logic [1:0]                     stop_code,
  input  logic [1:0]                     parity_mode,
  input  logic                           rx_empty,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [10:0]                    cfg_data,
  output logic [smpg_pkg::SPEED_BITS-1:0] speed_mul,
  output logic                           push,
  output smpg_pkg::cmd_t                 push_cmd,
  input  logic                           q_ready
);

  logic                                   swap_buttons;
  logic [1:0]                             port_select;
  logic [smpg_pkg::LAT_BITS-1:0]          latency_ticks;
  logic signed [smpg_pkg::COORD_BITS-1:0] cur_x, cur_y, prev_x, prev_y;
  logic [1:0]                             button_state;
  logic                                   line_was_high;
  logic                                   recentre_pending;
  logic [smpg_pkg::LAT_BITS-1:0]          countdown;

  logic accept;
  logic port_match;
  logic expire;
  logic framing_bad;
  logic send_packet;
  logic [1:0] btn_swapped;

  assign item_ready = q_ready;
  assign accept     = item_valid && item_ready;

  // classify the item
  assign port_match  = (port_select != 2'd0) && (line_port == port_select);
  assign expire      = accept && (action == smpg_pkg::ACT_TICK) &&
                       (countdown == smpg_pkg::LAT_BITS'(1));
  assign framing_bad = !rate_is_4800 || (char_bits != smpg_pkg::CHAR_BITS_OK) ||
                       (stop_code != smpg_pkg::STOP_TWO);
  assign send_packet = expire && rx_enabled && !framing_bad &&
                       (parity_mode == smpg_pkg::PARITY_NONE) && rx_empty;
  assign btn_swapped = swap_buttons ? {buttons[0], buttons[1]} : buttons;

  // command for the back part
  always_comb begin
    push          = 1'b0;
    push_cmd.kind = smpg_pkg::KIND_PACKET;
    if (expire && rx_enabled) begin
      if (framing_bad) begin
        push          = 1'b1;
        push_cmd.kind = smpg_pkg::KIND_FRAMING;
      end else if (parity_mode != smpg_pkg::PARITY_NONE) begin
        push          = 1'b1;
        push_cmd.kind = smpg_pkg::KIND_PARITY;
      end else if (rx_empty) begin
        push = 1'b1;
      end
    end
    push_cmd.buttons = button_state;
    push_cmd.dx      = smpg_pkg::DIFF_BITS'(cur_x) - smpg_pkg::DIFF_BITS'(prev_x);
    push_cmd.dy      = smpg_pkg::DIFF_BITS'(cur_y) - smpg_pkg::DIFF_BITS'(prev_y);
  end

  // state update; config writes are to come only while idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_mul        <= smpg_pkg::SPEED_RESET;
      swap_buttons     <= 1'b0;
      port_select      <= smpg_pkg::PORT_RESET;
      latency_ticks    <= smpg_pkg::LATENCY_RESET;
      cur_x            <= '0;
      cur_y            <= '0;
      prev_x           <= '0;
      prev_y           <= '0;
      button_state     <= 2'b00;
      line_was_high    <= 1'b0;
      recentre_pending <= 1'b1;
      countdown        <= '0;
    end else begin
      if (accept) begin
        unique case (action)
          smpg_pkg::ACT_POSITION: begin
            cur_x        <= smpg_pkg::coord_from16(pos_x);
            cur_y        <= smpg_pkg::coord_from16(pos_y);
            button_state <= btn_swapped;
            if (recentre_pending) begin
              recentre_pending <= 1'b0;
              prev_x           <= smpg_pkg::coord_from16(pos_x);
              prev_y           <= smpg_pkg::coord_from16(pos_y);
            end
          end
          smpg_pkg::ACT_LINE: begin
            if (port_match) begin
              if (line_level) begin
                line_was_high <= 1'b1;
              end else if (line_was_high) begin
                line_was_high <= 1'b0;
                if (countdown == '0) begin
                  countdown <= latency_ticks;
                end
              end
            end
          end
          smpg_pkg::ACT_TICK: begin
            if (countdown != '0) begin
              countdown <= countdown - smpg_pkg::LAT_BITS'(1);
            end
            if (send_packet) begin
              prev_x <= cur_x;
              prev_y <= cur_y;
            end
          end
          smpg_pkg::ACT_RECENTRE: begin
            recentre_pending <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (cfg_write) begin
        unique case (cfg_index)
          smpg_pkg::REG_SPEED_MUL: begin
            if (cfg_data[smpg_pkg::SPEED_BITS-1:0] != speed_mul) begin
              speed_mul        <= cfg_data[smpg_pkg::SPEED_BITS-1:0];
              recentre_pending <= 1'b1;
            end
          end
          smpg_pkg::REG_SWAP_BUTTONS: swap_buttons <= cfg_data[0];
          smpg_pkg::REG_PORT_SELECT: begin
            port_select <= cfg_data[1:0];
            if (cfg_data[1:0] == 2'd0) begin
              recentre_pending <= 1'b1;
              countdown        <= '0;
            end
          end
          smpg_pkg::REG_LATENCY_TICKS: latency_ticks <= cfg_data[smpg_pkg::LAT_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: sv/smpg_queue.sv
// short command queue between front and back parts
// register array with read and write pointers; uses smpg_pkg
module smpg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  smpg_pkg::cmd_t push_cmd,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output smpg_pkg::cmd_t pop_cmd
);

  smpg_pkg::cmd_t             entries [smpg_pkg::QDEPTH];
  logic [smpg_pkg::QAW-1:0]   wr_ptr, rd_ptr;
  logic [smpg_pkg::QAW:0]     count;
  logic                       do_push, do_pop;

  assign push_ready = (count != (smpg_pkg::QAW+1)'(smpg_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + smpg_pkg::QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + smpg_pkg::QAW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (smpg_pkg::QAW+1)'(1);
        2'b01:   count <= count - (smpg_pkg::QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/smpg_back.sv
// back part: scales the deltas, saturates them and sends the result bytes
// a product stage feeds a three-byte output shift register; uses smpg_pkg
module smpg_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [smpg_pkg::SPEED_BITS-1:0] speed_mul,
  input  logic                            q_valid,
  input  smpg_pkg::cmd_t                  q_cmd,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_kind,
  output logic [7:0]                      out_byte,
  output logic                            out_last
);

  localparam int PROD_BITS = smpg_pkg::DIFF_BITS + smpg_pkg::SPEED_BITS + 1;
  localparam int SC_BITS   = PROD_BITS - 8;

  // product stage
  logic                        a_valid;
  logic [1:0]                  a_kind;
  logic [1:0]                  a_buttons;
  logic signed [PROD_BITS-1:0] a_px, a_py;

  // output shift register
  logic       ser_valid;
  logic [1:0] ser_kind;
  logic [1:0] ser_rem;
  logic [7:0] ser_b0, ser_b1, ser_b2;

  logic signed [PROD_BITS-1:0] speed_s;
  logic signed [SC_BITS-1:0]   sc_x, sc_y;
  logic                        x_hi, x_lo, y_hi, y_lo;
  logic [7:0]                  dx_byte, dy_byte, status;
  logic                        ser_free, a_adv, a_load, out_fire;

  assign speed_s  = PROD_BITS'($signed({1'b0, speed_mul}));
  assign out_fire = ser_valid && out_ready;
  assign ser_free = !ser_valid || (out_fire && (ser_rem == 2'd1));
  assign a_adv    = a_valid && ser_free;
  assign a_load   = !a_valid || a_adv;
  assign q_pop    = q_valid && a_load;

  // floor scaling is the arithmetic shift; then saturate to one byte
  always_comb begin
    sc_x    = a_px[PROD_BITS-1:8];
    sc_y    = a_py[PROD_BITS-1:8];
    x_hi    = (sc_x > $signed(SC_BITS'(127)));
    x_lo    = (sc_x < $signed(-SC_BITS'(128)));
    y_hi    = (sc_y > $signed(SC_BITS'(127)));
    y_lo    = (sc_y < $signed(-SC_BITS'(128)));
    dx_byte = x_hi ? 8'h7f : (x_lo ? 8'h80 : sc_x[7:0]);
    dy_byte = y_hi ? 8'h7f : (y_lo ? 8'h80 : sc_y[7:0]);
    status  = {y_lo, y_hi, x_lo, x_hi, 2'b00, a_buttons};
  end

  // product stage load
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_kind    <= q_cmd.kind;
      a_buttons <= q_cmd.buttons;
      a_px      <= PROD_BITS'(q_cmd.dx) * speed_s;
      a_py      <= PROD_BITS'(q_cmd.dy) * speed_s;
    end
  end

  // output shift register: load a run, shift one byte per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_rem   <= 2'd0;
    end else if (ser_free) begin
      ser_valid <= a_valid;
      ser_rem   <= (a_kind == smpg_pkg::KIND_PACKET) ? 2'd3 : 2'd1;
    end else if (out_fire) begin
      ser_rem <= ser_rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_free) begin
      ser_kind <= a_kind;
      if (a_kind == smpg_pkg::KIND_PACKET) begin
        ser_b0 <= status;
        ser_b1 <= dx_byte;
        ser_b2 <= dy_byte;
      end else begin
        ser_b0 <= 8'h00;
        ser_b1 <= 8'h00;
        ser_b2 <= 8'h00;
      end
    end else if (out_fire) begin
      ser_b0 <= ser_b1;
      ser_b1 <= ser_b2;
    end
  end

  assign out_valid = ser_valid;
  assign out_kind  = ser_kind;
  assign out_byte  = ser_b0;
  assign out_last  = (ser_rem == 2'd1);

endmodule

// File: sv/smpg_checker.sv
// port-level checks for the serial mouse packet generator
// watches the top level's ports only; bound to serial_mouse_packet_generator
module smpg_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output dropped while stalled");

  // error reports are single results with a zero byte
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != smpg_pkg::KIND_PACKET) |-> m_tlast && (m_tdata == 8'h00))
    else $error("error report not a single zero byte");

  // only defined kinds appear
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == smpg_pkg::KIND_PACKET) || (m_tuser == smpg_pkg::KIND_FRAMING) ||
                 (m_tuser == smpg_pkg::KIND_PARITY))
    else $error("undefined result kind");

  // a packet continues without a gap until its last byte
  a_packet_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser == smpg_pkg::KIND_PACKET))
    else $error("packet run broken");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

endmodule

bind serial_mouse_packet_generator smpg_checker u_smpg_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
